@@ sv/mtlf_pkg.sv @@
// ============================================================================
// Motion-triggered LED fader package
// Shared types, register codes and reset values for the fader core.
// ============================================================================
package mtlf_pkg;

    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned STEP_W     = 8;
    localparam int unsigned OVF_CNT_W  = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_STEP    = 3'd0,
        CFG_MID_STEP     = 3'd1,
        CFG_FAST_STEP    = 3'd2,
        CFG_FIRST_BREAK  = 3'd3,
        CFG_SECOND_BREAK = 3'd4,
        CFG_FADEOUT_STEP = 3'd5,
        CFG_HOLD_LIMIT   = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0]    SLOW_STEP_RST    = 8'd50;
    localparam logic [STEP_W-1:0]    MID_STEP_RST     = 8'd5;
    localparam logic [STEP_W-1:0]    FAST_STEP_RST    = 8'd2;
    localparam logic [DUTY_W-1:0]    FIRST_BREAK_RST  = 8'd20;
    localparam logic [DUTY_W-1:0]    SECOND_BREAK_RST = 8'd150;
    localparam logic [STEP_W-1:0]    FADEOUT_STEP_RST = 8'd5;
    localparam logic [OVF_CNT_W-1:0] HOLD_LIMIT_RST   = 12'd3000;

    // Duty values at the ends of the ramps.
    localparam logic [DUTY_W-1:0] DUTY_FULL       = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_FADE_START = 8'd254;
    localparam logic [DUTY_W-1:0] DUTY_OFF        = 8'd0;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FADEIN  = 2'd1,
        PH_HOLD    = 2'd2,
        PH_FADEOUT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [STEP_W-1:0]    slow_step_ms;
        logic [STEP_W-1:0]    mid_step_ms;
        logic [STEP_W-1:0]    fast_step_ms;
        logic [DUTY_W-1:0]    first_break;
        logic [DUTY_W-1:0]    second_break;
        logic [STEP_W-1:0]    fadeout_step_ms;
        logic [OVF_CNT_W-1:0] hold_limit;
    } cfg_t;

    typedef struct packed {
        logic ms_tick;
        logic overflow_tick;
        logic sensor_trigger;
    } event_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [1:0]        phase;
        logic              running;
    } status_t;

endpackage

@@ sv/mtlf_stream_if.sv @@
// ============================================================================
// Fader stream interface
// Valid/ready channel that carries one payload word per request.
// ============================================================================
interface mtlf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ sv/motion_triggered_led_fader_core.sv @@
// ============================================================================
// Motion-triggered LED fader core
// Event-driven fade sequencer that turns tick and sensor events into a duty.
// ============================================================================
// Each request on the items channel carries a millisecond tick, a timer
// overflow tick and a sensor trigger, and produces exactly one request on the
// results channel with the PWM duty, the sequencer phase and the run flag.
// A trigger sets the run flag and restarts the hold counter; overflow ticks
// count toward hold_limit, after which the run flag clears. The sequencer
// fades the duty up through three configurable step rates, holds at full
// brightness while the run flag stays set, then fades down at one configurable rate.
// The core takes one request every clock cycle while the skid entry is
// empty: all of the work for a request is a single pass of short logic on
// the state registers, and the result is registered in the result register.
// A two-entry output buffer (result register plus skid register) keeps
// items flowing when the results side stalls, the skid register taking the
// result; items stall only once both entries are full. Configuration writes
// take effect at once and should be issued only while no request is in flight.
// ============================================================================
module motion_triggered_led_fader_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mtlf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtlf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    mtlf_stream_if.sink                     items,
    mtlf_stream_if.source                   results
);

    // Configuration registers.
    mtlf_pkg::cfg_t cfg_reg;

    // Sequencer state.
    logic                                run_reg;
    logic                                run_next;
    logic [mtlf_pkg::OVF_CNT_W-1:0]      ovf_cnt_reg;
    logic [mtlf_pkg::OVF_CNT_W-1:0]      ovf_cnt_next;
    mtlf_pkg::phase_t                    phase_reg;
    mtlf_pkg::phase_t                    phase_next;
    logic [mtlf_pkg::DUTY_W-1:0]         duty_reg;
    logic [mtlf_pkg::DUTY_W-1:0]         duty_next;
    logic [mtlf_pkg::STEP_W-1:0]         ms_cnt_reg;
    logic [mtlf_pkg::STEP_W-1:0]         ms_cnt_next;

    // Output buffer: the result register and a skid entry behind it.
    mtlf_pkg::status_t                   out_reg;
    logic                                out_valid_reg;
    mtlf_pkg::status_t                   skid_reg;
    logic                                skid_valid_reg;

    mtlf_pkg::event_t                    ev;
    mtlf_pkg::status_t                   status_new;
    logic                                accept;
    logic                                out_free;

    assign ev       = items.payload;
    assign out_free = !out_valid_reg || results.ready;

    // Items are taken as long as the skid entry is empty.
    assign items.ready   = !skid_valid_reg;
    assign accept        = items.valid && !skid_valid_reg;
    assign results.valid = out_valid_reg;
    assign results.payload = out_reg;

    // ------------------------------------------------------------------------
    // Configuration writes. Unknown indexes are ignored.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_step_ms    <= mtlf_pkg::SLOW_STEP_RST;
            cfg_reg.mid_step_ms     <= mtlf_pkg::MID_STEP_RST;
            cfg_reg.fast_step_ms    <= mtlf_pkg::FAST_STEP_RST;
            cfg_reg.first_break     <= mtlf_pkg::FIRST_BREAK_RST;
            cfg_reg.second_break    <= mtlf_pkg::SECOND_BREAK_RST;
            cfg_reg.fadeout_step_ms <= mtlf_pkg::FADEOUT_STEP_RST;
            cfg_reg.hold_limit      <= mtlf_pkg::HOLD_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mtlf_pkg::CFG_SLOW_STEP:    cfg_reg.slow_step_ms    <= cfg_wr_data[7:0];
                mtlf_pkg::CFG_MID_STEP:     cfg_reg.mid_step_ms     <= cfg_wr_data[7:0];
                mtlf_pkg::CFG_FAST_STEP:    cfg_reg.fast_step_ms    <= cfg_wr_data[7:0];
                mtlf_pkg::CFG_FIRST_BREAK:  cfg_reg.first_break     <= cfg_wr_data[7:0];
                mtlf_pkg::CFG_SECOND_BREAK: cfg_reg.second_break    <= cfg_wr_data[7:0];
                mtlf_pkg::CFG_FADEOUT_STEP: cfg_reg.fadeout_step_ms <= cfg_wr_data[7:0];
                mtlf_pkg::CFG_HOLD_LIMIT:   cfg_reg.hold_limit      <= cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Next-state logic. Events are applied in the order overflow, trigger,
    // millisecond tick; phase changes that follow directly from the run flag
    // (idle to fade-in, hold to fade-out) are applied both before and after
    // the millisecond step so that transitions chain within one request.
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [mtlf_pkg::OVF_CNT_W-1:0] cnt_inc;
        logic [mtlf_pkg::STEP_W-1:0]    ms_inc;
        logic [mtlf_pkg::STEP_W-1:0]    step_len;
        logic                           run_v;
        logic [mtlf_pkg::OVF_CNT_W-1:0] cnt_v;
        mtlf_pkg::phase_t               ph_v;
        logic [mtlf_pkg::DUTY_W-1:0]    duty_v;
        logic [mtlf_pkg::STEP_W-1:0]    ms_v;

        run_v  = run_reg;
        cnt_v  = ovf_cnt_reg;
        ph_v   = phase_reg;
        duty_v = duty_reg;
        ms_v   = ms_cnt_reg;

        // Hold counter wraps at its width, so a limit below the count is
        // only met after the wrap.
        cnt_inc = ovf_cnt_reg + 1'b1;
        if (ev.overflow_tick)
        begin
            cnt_v = cnt_inc;
            if (cnt_inc == cfg_reg.hold_limit)
            begin
                run_v = 1'b0;
                cnt_v = '0;
            end
        end
        if (ev.sensor_trigger)
        begin
            run_v = 1'b1;
            cnt_v = '0;
        end

        // First settle.
        if (ph_v == mtlf_pkg::PH_IDLE && run_v)
        begin
            ph_v   = mtlf_pkg::PH_FADEIN;
            duty_v = mtlf_pkg::DUTY_OFF;
            ms_v   = '0;
        end
        if (ph_v == mtlf_pkg::PH_HOLD && !run_v)
        begin
            ph_v   = mtlf_pkg::PH_FADEOUT;
            duty_v = mtlf_pkg::DUTY_FADE_START;
            ms_v   = '0;
        end

        // Step length for the current duty; out-of-order breakpoints simply
        // fall through the comparisons.
        priority if (duty_v < cfg_reg.first_break)
            step_len = cfg_reg.slow_step_ms;
        else if (duty_v < cfg_reg.second_break)
            step_len = cfg_reg.mid_step_ms;
        else
            step_len = cfg_reg.fast_step_ms;

        // The ms counter wraps at its width; a step of zero acts like a step of
        // one, since every incremented count meets it.
        ms_inc = ms_v + 1'b1;
        if (ev.ms_tick)
        begin
            if (ph_v == mtlf_pkg::PH_FADEIN)
            begin
                ms_v = ms_inc;
                if (ms_inc >= step_len)
                begin
                    ms_v   = '0;
                    duty_v = duty_v + 1'b1;
                    if (duty_v == mtlf_pkg::DUTY_FULL)
                    begin
                        ph_v = mtlf_pkg::PH_HOLD;
                    end
                end
            end
            else if (ph_v == mtlf_pkg::PH_FADEOUT)
            begin
                ms_v = ms_inc;
                if (ms_inc >= cfg_reg.fadeout_step_ms)
                begin
                    ms_v = '0;
                    if (duty_v == mtlf_pkg::DUTY_OFF)
                    begin
                        ph_v = mtlf_pkg::PH_IDLE;
                    end
                    else
                    begin
                        duty_v = duty_v - 1'b1;
                    end
                end
            end
        end

        // Second settle; it changes nothing when no ms step was taken.
        if (ph_v == mtlf_pkg::PH_IDLE && run_v)
        begin
            ph_v   = mtlf_pkg::PH_FADEIN;
            duty_v = mtlf_pkg::DUTY_OFF;
            ms_v   = '0;
        end
        if (ph_v == mtlf_pkg::PH_HOLD && !run_v)
        begin
            ph_v   = mtlf_pkg::PH_FADEOUT;
            duty_v = mtlf_pkg::DUTY_FADE_START;
            ms_v   = '0;
        end

        run_next     = run_v;
        ovf_cnt_next = cnt_v;
        phase_next   = ph_v;
        duty_next    = duty_v;
        ms_cnt_next  = ms_v;
    end

    // Result word for the request being accepted.
    always_comb
    begin
        status_new.duty    = duty_next;
        status_new.phase   = phase_next;
        status_new.running = run_next;
    end

    // ------------------------------------------------------------------------
    // State registers advance only on an accepted request.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            ovf_cnt_reg <= '0;
            phase_reg   <= mtlf_pkg::PH_IDLE;
            duty_reg    <= '0;
            ms_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            run_reg     <= run_next;
            ovf_cnt_reg <= ovf_cnt_next;
            phase_reg   <= phase_next;
            duty_reg    <= duty_next;
            ms_cnt_reg  <= ms_cnt_next;
        end
    end

    // ------------------------------------------------------------------------
    // Output buffer control. The skid entry always holds the younger result,
    // so it moves into the result register before anything new does.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= status_new;
            end
        end
        else if (accept)
        begin
            skid_reg <= status_new;
        end
    end

endmodule
